[design/jsp_pkg.sv]
// shared types, constants and the microcode program of the julia set point test unit
// used by every module of the block; depends on nothing
package jsp_pkg;

    // fixed-point format and field widths
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 20;
    localparam int PIX_W     = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int NUM_W     = PIX_W + DATA_W + 2;
    localparam int COLOR_W   = 8;
    localparam int PC_W      = 4;

    // |z|^2 escape bound, 1000 in unsigned Q25.40
    localparam logic [PROD_W:0] ESCAPE_LIMIT = (PROD_W + 1)'(1000) << (2 * FRAC_BITS);

    localparam logic [COLOR_W-1:0] COLOR_FULL = 8'hFF;
    localparam logic [COLOR_W-1:0] COLOR_NONE = 8'h00;

    // register reset values
    localparam logic signed [DATA_W-1:0] X_LEFT_RESET   = -32'sd1572864;
    localparam logic signed [DATA_W-1:0] X_RIGHT_RESET  = 32'sd1572864;
    localparam logic signed [DATA_W-1:0] Y_BOTTOM_RESET = -32'sd1572864;
    localparam logic signed [DATA_W-1:0] Y_TOP_RESET    = 32'sd1572864;
    localparam logic [PIX_W-1:0]         WIDTH_RESET    = 16'd1024;
    localparam logic [PIX_W-1:0]         HEIGHT_RESET   = 16'd1024;
    localparam logic signed [DATA_W-1:0] C_REAL_RESET   = -32'sd838861;
    localparam logic signed [DATA_W-1:0] C_IMAG_RESET   = 32'sd163578;

    // register map indexes
    typedef enum logic [2:0] {
        REG_X_LEFT,
        REG_X_RIGHT,
        REG_Y_BOTTOM,
        REG_Y_TOP,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_C_REAL,
        REG_C_IMAG
    } reg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_left;
        logic signed [DATA_W-1:0] x_right;
        logic signed [DATA_W-1:0] y_bottom;
        logic signed [DATA_W-1:0] y_top;
        logic [PIX_W-1:0]         image_width;
        logic [PIX_W-1:0]         image_height;
        logic signed [DATA_W-1:0] c_real;
        logic signed [DATA_W-1:0] c_imag;
    } cfg_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_MAP_X,
        OP_MAP_Y,
        OP_SUM_Y,
        OP_DIV_START,
        OP_LOAD_Z,
        OP_MUL,
        OP_ITER,
        OP_RESULT
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_INPUT,
        CND_DIV_BUSY,
        CND_NOT_EXIT,
        CND_OUT_FREE
    } cond_t;

    typedef logic [PC_W-1:0] pc_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic iter_exit;
        logic out_free;
    } dp_status_t;

    // program step addresses
    localparam pc_t STEP_WAIT   = 4'd0;
    localparam pc_t STEP_MAP_X  = 4'd1;
    localparam pc_t STEP_MAP_Y  = 4'd2;
    localparam pc_t STEP_SUM_Y  = 4'd3;
    localparam pc_t STEP_DIV    = 4'd4;
    localparam pc_t STEP_DIV_WT = 4'd5;
    localparam pc_t STEP_LOAD_Z = 4'd6;
    localparam pc_t STEP_MUL    = 4'd7;
    localparam pc_t STEP_ITER   = 4'd8;
    localparam pc_t STEP_DONE   = 4'd9;
    localparam pc_t STEP_HOLD   = 4'd10;

    // control store: a jump is taken when its condition holds, else the next step follows
    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        w = '{op: OP_NOP, cond: CND_ALWAYS, target: STEP_WAIT};
        case (pc)
            STEP_WAIT:   w = '{op: OP_ACCEPT,    cond: CND_NO_INPUT, target: STEP_WAIT};
            STEP_MAP_X:  w = '{op: OP_MAP_X,     cond: CND_NEVER,    target: STEP_WAIT};
            STEP_MAP_Y:  w = '{op: OP_MAP_Y,     cond: CND_NEVER,    target: STEP_WAIT};
            STEP_SUM_Y:  w = '{op: OP_SUM_Y,     cond: CND_NEVER,    target: STEP_WAIT};
            STEP_DIV:    w = '{op: OP_DIV_START, cond: CND_NEVER,    target: STEP_WAIT};
            STEP_DIV_WT: w = '{op: OP_NOP,       cond: CND_DIV_BUSY, target: STEP_DIV_WT};
            STEP_LOAD_Z: w = '{op: OP_LOAD_Z,    cond: CND_NEVER,    target: STEP_WAIT};
            STEP_MUL:    w = '{op: OP_MUL,       cond: CND_NEVER,    target: STEP_WAIT};
            STEP_ITER:   w = '{op: OP_ITER,      cond: CND_NOT_EXIT, target: STEP_MUL};
            STEP_DONE:   w = '{op: OP_RESULT,    cond: CND_OUT_FREE, target: STEP_WAIT};
            STEP_HOLD:   w = '{op: OP_NOP,       cond: CND_ALWAYS,   target: STEP_DONE};
            default:     w = '{op: OP_NOP,       cond: CND_ALWAYS,   target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

[design/jsp_divider.sv]
// bit-serial signed-by-unsigned divider for the coordinate mapping, truncating toward zero
// depends on jsp_pkg
module jsp_divider (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [jsp_pkg::NUM_W-1:0]   numer,
    input  logic [jsp_pkg::PIX_W-1:0]          denom,
    output logic                               busy,
    output logic signed [jsp_pkg::DATA_W-1:0]  quot
);
    import jsp_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [PIX_W-1:0] rem_reg, rem_next;
    logic [PIX_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [PIX_W:0]   rem_shift;
    logic             fits;

    // one quotient bit per cycle, restoring form on the magnitude
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
            rem_next  = '0;
            den_next  = denom;
            neg_next  = numer[NUM_W-1];
        end else if (busy_reg) begin
            rem_next = fits ? PIX_W'(rem_shift - {1'b0, den_reg}) : PIX_W'(rem_shift);
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // sign restore on the low word, the quotient lies between the axis limits
    assign busy = busy_reg;
    assign quot = neg_reg ? -signed'(quo_reg[DATA_W-1:0]) : signed'(quo_reg[DATA_W-1:0]);

endmodule

[design/jsp_datapath.sv]
// datapath of the julia set point test unit: pixel mapping, complex square step,
// escape test and output register, driven by the control word; depends on jsp_pkg, jsp_divider
module jsp_datapath #(
    parameter int MAX_ITER = 200
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  jsp_pkg::uword_t                     ctrl,
    input  jsp_pkg::cfg_t                       cfg,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [jsp_pkg::PIX_W-1:0]           s_column,
    input  logic [jsp_pkg::PIX_W-1:0]           s_row,
    output jsp_pkg::dp_status_t                 status,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic                                m_in_set,
    output logic [jsp_pkg::COLOR_W-1:0]         m_blue,
    output logic [jsp_pkg::COLOR_W-1:0]         m_green,
    output logic [jsp_pkg::COLOR_W-1:0]         m_red
);
    import jsp_pkg::*;

    localparam int ITER_W = $clog2(MAX_ITER + 1);
    localparam logic [ITER_W-1:0] ITER_MAX = ITER_W'(MAX_ITER);
    localparam int IM_W  = PROD_W - FRAC_BITS + 3;

    // last index of an axis, one for a degenerate size so the division is by one
    function automatic logic [PIX_W-1:0] axis_last(input logic [PIX_W-1:0] n);
        return (n < PIX_W'(2)) ? PIX_W'(1) : n - PIX_W'(1);
    endfunction

    // clamped pixel index, zero for a degenerate size so the mapping gives the low limit
    function automatic logic [PIX_W-1:0] axis_index(input logic [PIX_W-1:0] n,
                                                    input logic [PIX_W-1:0] idx);
        logic [PIX_W-1:0] last;
        last = n - PIX_W'(1);
        if (n < PIX_W'(2)) begin
            return '0;
        end
        return (idx > last) ? last : idx;
    endfunction

    // saturate a wide sum to the signed data range
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [IM_W-1:0] v);
        logic [IM_W-DATA_W:0] top;
        top = v[IM_W-1:DATA_W-1];
        if (top == '0 || top == '1) begin
            return v[DATA_W-1:0];
        end
        return v[IM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    logic [PIX_W-1:0]         last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic [PIX_W-1:0]         idx_x_reg, idx_x_next, idx_y_reg, idx_y_next;
    logic signed [PROD_W-1:0] prod_a_reg, prod_a_next, prod_b_reg, prod_b_next;
    logic signed [PROD_W-1:0] prod_c_reg, prod_c_next;
    logic signed [NUM_W-1:0]  num_x_reg, num_x_next, num_y_reg, num_y_next;
    logic signed [DATA_W-1:0] zr_reg, zr_next, zi_reg, zi_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic                     escaped_reg, escaped_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     in_set_reg, in_set_next;

    logic signed [DATA_W-1:0] mul_a1, mul_a2, mul_b1, mul_b2, mul_c1, mul_c2;
    logic signed [PROD_W-1:0] prod_a, prod_b, prod_c, prod_sum, re_diff;
    logic [PROD_W:0]          mag_sum;
    logic                     escape, iter_exit, out_free, result_load;
    logic signed [IM_W-1:0]   re_sum, im_sum;
    logic signed [DATA_W-1:0] quot_x, quot_y;
    logic                     busy_x, busy_y, div_start;

    // multiplier operand selection, one operand pair per multiplier
    always_comb begin
        unique case (ctrl.op)
            OP_MAP_X: begin
                mul_a1 = signed'(DATA_W'(last_x_reg - idx_x_reg));
                mul_a2 = cfg.x_left;
                mul_b1 = signed'(DATA_W'(idx_x_reg));
                mul_b2 = cfg.x_right;
            end
            OP_MAP_Y: begin
                mul_a1 = signed'(DATA_W'(last_y_reg - idx_y_reg));
                mul_a2 = cfg.y_bottom;
                mul_b1 = signed'(DATA_W'(idx_y_reg));
                mul_b2 = cfg.y_top;
            end
            default: begin
                mul_a1 = zr_reg;
                mul_a2 = zr_reg;
                mul_b1 = zi_reg;
                mul_b2 = zi_reg;
            end
        endcase
    end

    assign mul_c1 = zr_reg;
    assign mul_c2 = zi_reg;
    assign prod_a = PROD_W'(mul_a1) * PROD_W'(mul_a2);
    assign prod_b = PROD_W'(mul_b1) * PROD_W'(mul_b2);
    assign prod_c = PROD_W'(mul_c1) * PROD_W'(mul_c2);

    // mapping numerator from the registered product pair
    assign prod_sum = prod_a_reg + prod_b_reg;

    // escape test on the squares of the current point
    assign mag_sum   = {1'b0, prod_a_reg} + {1'b0, prod_b_reg};
    assign escape    = mag_sum > ESCAPE_LIMIT;
    assign iter_exit = ((iter_reg != '0) && escape) || (iter_reg == ITER_MAX);

    // next point: floor shifts are the upper product bits, then add c and saturate
    assign re_diff = prod_a_reg - prod_b_reg;
    assign re_sum  = IM_W'(signed'(re_diff[PROD_W-1:FRAC_BITS])) + IM_W'(cfg.c_real);
    assign im_sum  = IM_W'(signed'(prod_c_reg[PROD_W-1:FRAC_BITS-1])) + IM_W'(cfg.c_imag);

    assign out_free    = !m_valid_reg || m_ready;
    assign result_load = (ctrl.op == OP_RESULT) && out_free;
    assign div_start   = ctrl.op == OP_DIV_START;
    assign s_ready     = aresetn && (ctrl.op == OP_ACCEPT);

    // per-step register updates
    always_comb begin
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        idx_x_next   = idx_x_reg;
        idx_y_next   = idx_y_reg;
        prod_a_next  = prod_a_reg;
        prod_b_next  = prod_b_reg;
        prod_c_next  = prod_c_reg;
        num_x_next   = num_x_reg;
        num_y_next   = num_y_reg;
        zr_next      = zr_reg;
        zi_next      = zi_reg;
        iter_next    = iter_reg;
        escaped_next = escaped_reg;
        unique case (ctrl.op)
            OP_ACCEPT: begin
                if (s_valid) begin
                    last_x_next = axis_last(cfg.image_width);
                    last_y_next = axis_last(cfg.image_height);
                    idx_x_next  = axis_index(cfg.image_width, s_column);
                    idx_y_next  = axis_index(cfg.image_height, s_row);
                end
            end
            OP_MAP_X: begin
                prod_a_next = prod_a;
                prod_b_next = prod_b;
            end
            OP_MAP_Y: begin
                prod_a_next = prod_a;
                prod_b_next = prod_b;
                num_x_next  = prod_sum[NUM_W-1:0];
            end
            OP_SUM_Y: begin
                num_y_next = prod_sum[NUM_W-1:0];
            end
            OP_LOAD_Z: begin
                zr_next      = quot_x;
                zi_next      = quot_y;
                iter_next    = '0;
                escaped_next = 1'b0;
            end
            OP_MUL: begin
                prod_a_next = prod_a;
                prod_b_next = prod_b;
                prod_c_next = prod_c;
            end
            OP_ITER: begin
                zr_next      = sat_data(IM_W'(re_sum));
                zi_next      = sat_data(im_sum);
                escaped_next = (iter_reg != '0) && escape;
                if (!iter_exit) begin
                    iter_next = iter_reg + ITER_W'(1);
                end
            end
            default: ;
        endcase
    end

    // output register, refilled as soon as the held transaction leaves
    always_comb begin
        m_valid_next = m_valid_reg;
        in_set_next  = in_set_reg;
        if (result_load) begin
            m_valid_next = 1'b1;
            in_set_next  = !escaped_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            iter_reg    <= '0;
            escaped_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            iter_reg    <= iter_next;
            escaped_reg <= escaped_next;
        end
        in_set_reg <= in_set_next;
        last_x_reg <= last_x_next;
        last_y_reg <= last_y_next;
        idx_x_reg  <= idx_x_next;
        idx_y_reg  <= idx_y_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        prod_c_reg <= prod_c_next;
        num_x_reg  <= num_x_next;
        num_y_reg  <= num_y_next;
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
    end

    // one divider per axis, both started together
    jsp_divider u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (num_x_reg),
        .denom   (last_x_reg),
        .busy    (busy_x),
        .quot    (quot_x)
    );

    jsp_divider u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (num_y_reg),
        .denom   (last_y_reg),
        .busy    (busy_y),
        .quot    (quot_y)
    );

    assign status.in_valid  = s_valid;
    assign status.div_busy  = busy_x || busy_y;
    assign status.iter_exit = iter_exit;
    assign status.out_free  = out_free;

    assign m_valid  = m_valid_reg;
    assign m_in_set = in_set_reg;
    assign m_blue   = in_set_reg ? COLOR_NONE : COLOR_FULL;
    assign m_green  = in_set_reg ? COLOR_NONE : COLOR_FULL;
    assign m_red    = COLOR_FULL;

`ifndef SYNTHESIS
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg <= ITER_MAX)
        else $error("iteration count beyond limit");

    a_load_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == OP_LOAD_Z |-> !status.div_busy)
        else $error("point loaded while a division runs");

    a_loop_back: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == OP_ITER && !iter_exit |=> ctrl.op == OP_MUL)
        else $error("iteration loop did not return to the multiply step");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(ctrl.op) == OP_RESULT)
        else $error("result appeared outside the result step");
`endif

endmodule

[design/jsp_sequencer.sv]
// microprogram sequencer: step counter, control store lookup and conditional jumps
// depends on jsp_pkg
module jsp_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  jsp_pkg::dp_status_t  status,
    output jsp_pkg::uword_t      ctrl
);
    import jsp_pkg::*;

    pc_t    pc_reg, pc_next;
    uword_t uword;
    logic   take;

    assign uword = ucode_rom(pc_reg);

    // jump condition of the current step
    always_comb begin
        unique case (uword.cond)
            CND_NEVER:    take = 1'b0;
            CND_ALWAYS:   take = 1'b1;
            CND_NO_INPUT: take = !status.in_valid;
            CND_DIV_BUSY: take = status.div_busy;
            CND_NOT_EXIT: take = !status.iter_exit;
            CND_OUT_FREE: take = status.out_free;
            default:      take = 1'b1;
        endcase
    end

    assign pc_next = take ? uword.target : pc_reg + PC_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = uword;

endmodule

[design/julia_set_point_test_unit.sv]
// top level of the julia set point test unit: configuration registers and the
// sequencer/datapath pair; depends on jsp_pkg, jsp_sequencer, jsp_datapath
//
// Tests one pixel per transaction for membership in the julia set of z*z + c, in signed
// Q11.20 fixed point. The pixel is mapped onto the configured rectangle, then iterated up
// to MAX_ITER times; a point whose |z|^2 passes 1000 is white, else red. The time a pixel
// takes from acceptance to result is set by the bit-serial coordinate dividers and by the
// iteration loop, which alternates a step for the three products with a step for the update
// and escape test, and so grows with the iteration at which the pixel leaves. A finished
// result waits in an output register, so the next pixel is taken while it is still held.
// Registers sit at byte addresses 4*i: x_left, x_right, y_bottom, y_top, image_width,
// image_height, c_real, c_imag; write them only while the unit is idle.
module julia_set_point_test_unit #(
    parameter int MAX_ITER = 200
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [jsp_pkg::PIX_W-1:0]    s_column,
    input  logic [jsp_pkg::PIX_W-1:0]    s_row,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_in_set,
    output logic [jsp_pkg::COLOR_W-1:0]  m_blue,
    output logic [jsp_pkg::COLOR_W-1:0]  m_green,
    output logic [jsp_pkg::COLOR_W-1:0]  m_red
);
    import jsp_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    reg_idx_t   reg_idx;
    logic       wr_en;
    uword_t     ctrl;
    dp_status_t status;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_X_LEFT:       cfg_next.x_left       = signed'(pwdata);
                REG_X_RIGHT:      cfg_next.x_right      = signed'(pwdata);
                REG_Y_BOTTOM:     cfg_next.y_bottom     = signed'(pwdata);
                REG_Y_TOP:        cfg_next.y_top        = signed'(pwdata);
                REG_IMAGE_WIDTH:  cfg_next.image_width  = pwdata[PIX_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = pwdata[PIX_W-1:0];
                REG_C_REAL:       cfg_next.c_real       = signed'(pwdata);
                REG_C_IMAG:       cfg_next.c_imag       = signed'(pwdata);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_left       <= X_LEFT_RESET;
            cfg_reg.x_right      <= X_RIGHT_RESET;
            cfg_reg.y_bottom     <= Y_BOTTOM_RESET;
            cfg_reg.y_top        <= Y_TOP_RESET;
            cfg_reg.image_width  <= WIDTH_RESET;
            cfg_reg.image_height <= HEIGHT_RESET;
            cfg_reg.c_real       <= C_REAL_RESET;
            cfg_reg.c_imag       <= C_IMAG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb begin
        unique case (reg_idx)
            REG_X_LEFT:       prdata = cfg_reg.x_left;
            REG_X_RIGHT:      prdata = cfg_reg.x_right;
            REG_Y_BOTTOM:     prdata = cfg_reg.y_bottom;
            REG_Y_TOP:        prdata = cfg_reg.y_top;
            REG_IMAGE_WIDTH:  prdata = 32'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = 32'(cfg_reg.image_height);
            REG_C_REAL:       prdata = cfg_reg.c_real;
            REG_C_IMAG:       prdata = cfg_reg.c_imag;
            default:          prdata = '0;
        endcase
    end

    jsp_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    jsp_datapath #(
        .MAX_ITER (MAX_ITER)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_column (s_column),
        .s_row    (s_row),
        .status   (status),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_in_set (m_in_set),
        .m_blue   (m_blue),
        .m_green  (m_green),
        .m_red    (m_red)
    );

endmodule

[tb/sv/julia_set_point_test_unit_tb.sv]
// self-checking testbench for the julia set point test unit: directed and random pixels,
// several plane settings over the register port, random idling on both streams
// depends on jsp_pkg and julia_set_point_test_unit
module julia_set_point_test_unit_tb;

    import jsp_pkg::*;

    localparam int     ITER_LIMIT  = 200;
    localparam int     CYCLE_LIMIT = 4_000_000;
    localparam int     HOLD_CYCLES = 3000;
    localparam longint SAT_MAX     = 64'sd2147483647;
    localparam longint SAT_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic [PIX_W-1:0] column;
        logic [PIX_W-1:0] row;
    } pixel_t;

    // expected color of one pixel, tagged with its coordinates for messages
    typedef struct packed {
        logic [PIX_W-1:0]   column;
        logic [PIX_W-1:0]   row;
        logic               in_set;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } pixel_color_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [4:0]         paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid  = 1'b0;
    logic               s_ready;
    logic [PIX_W-1:0]   s_column = '0;
    logic [PIX_W-1:0]   s_row    = '0;
    logic               m_valid;
    logic               m_ready  = 1'b0;
    logic               m_in_set;
    logic [COLOR_W-1:0] m_blue;
    logic [COLOR_W-1:0] m_green;
    logic [COLOR_W-1:0] m_red;

    // shadow of the plane registers, starts at the reset values
    cfg_t plane = '{x_left: X_LEFT_RESET, x_right: X_RIGHT_RESET,
                    y_bottom: Y_BOTTOM_RESET, y_top: Y_TOP_RESET,
                    image_width: WIDTH_RESET, image_height: HEIGHT_RESET,
                    c_real: C_REAL_RESET, c_imag: C_IMAG_RESET};

    pixel_t       pixel_queue[$];
    pixel_color_t expected_colors[$];
    pixel_t       next_pixel;
    pixel_color_t want;
    int           items_sent      = 0;
    int           results_checked = 0;
    int           errors          = 0;
    int           cycle_count     = 0;
    int           feed_gap        = 0;
    int           drain_gap       = 0;
    int           hold_left       = 0;
    bit           feed_idle_on    = 1'b1;
    bit           drain_idle_on   = 1'b1;

    julia_set_point_test_unit #(
        .MAX_ITER(ITER_LIMIT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_column(s_column),
        .s_row(s_row),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_in_set(m_in_set),
        .m_blue(m_blue),
        .m_green(m_green),
        .m_red(m_red)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // pixel index to plane coordinate, truncating toward zero
    function automatic int axis_coord(input int lo, input int hi,
                                      input logic [PIX_W-1:0] n, input logic [PIX_W-1:0] idx);
        longint last;
        longint pos;
        longint num;
        if (n < 2) return lo;
        last = n - 1;
        pos  = idx;
        if (pos > last) pos = last;
        num = (last - pos) * longint'(lo) + pos * longint'(hi);
        return int'(num / last);
    endfunction

    function automatic int clamp32(input longint v);
        if (v > SAT_MAX) return int'(SAT_MAX);
        if (v < SAT_MIN) return int'(SAT_MIN);
        return int'(v);
    endfunction

    // escape-time loop of z = z*z + c in Q11.20
    function automatic bit orbit_bounded(input int z_re0, input int z_im0,
                                         input int c_re, input int c_im);
        int          z_re;
        int          z_im;
        int          k;
        longint      re_sq;
        longint      im_sq;
        longint      re_im;
        logic [63:0] mag;
        z_re = z_re0;
        z_im = z_im0;
        for (k = 0; k < ITER_LIMIT; k++) begin
            re_sq = longint'(z_re) * longint'(z_re);
            im_sq = longint'(z_im) * longint'(z_im);
            re_im = longint'(z_re) * longint'(z_im);
            z_re  = clamp32(((re_sq - im_sq) >>> FRAC_BITS) + longint'(c_re));
            z_im  = clamp32((re_im >>> (FRAC_BITS - 1)) + longint'(c_im));
            re_sq = longint'(z_re) * longint'(z_re);
            im_sq = longint'(z_im) * longint'(z_im);
            mag   = re_sq + im_sq;
            if (mag > ESCAPE_LIMIT) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic pixel_color_t predict_pixel(input logic [PIX_W-1:0] column,
                                                   input logic [PIX_W-1:0] row);
        pixel_color_t px;
        int           x;
        int           y;
        x = axis_coord(plane.x_left, plane.x_right, plane.image_width, column);
        y = axis_coord(plane.y_bottom, plane.y_top, plane.image_height, row);
        px.column = column;
        px.row    = row;
        px.in_set = orbit_bounded(x, y, plane.c_real, plane.c_imag);
        px.blue   = px.in_set ? COLOR_NONE : COLOR_FULL;
        px.green  = px.in_set ? COLOR_NONE : COLOR_FULL;
        px.red    = COLOR_FULL;
        return px;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_len(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 60);
        return $urandom_range(100, 600);
    endfunction

    function automatic logic [PIX_W-1:0] rand_index(input logic [PIX_W-1:0] n);
        if (n == 0 || $urandom_range(0, 3) == 0) return PIX_W'($urandom_range(0, 65535));
        return PIX_W'($urandom_range(0, n - 1));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int exp_v,
                               input pixel_color_t pend);
        if (got != exp_v)
            report_mismatch($sformatf("%s got %0d want %0d (column %0d row %0d)",
                                      name, got, exp_v, pend.column, pend.row));
    endtask

    // register write: setup phase, then access phase until pready
    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_X_LEFT:       plane.x_left       = value;
            REG_X_RIGHT:      plane.x_right      = value;
            REG_Y_BOTTOM:     plane.y_bottom     = value;
            REG_Y_TOP:        plane.y_top        = value;
            REG_IMAGE_WIDTH:  plane.image_width  = value[PIX_W-1:0];
            REG_IMAGE_HEIGHT: plane.image_height = value[PIX_W-1:0];
            REG_C_REAL:       plane.c_real       = value;
            REG_C_IMAG:       plane.c_imag       = value;
            default: ;
        endcase
    endtask

    task automatic queue_pixel(input int column, input int row);
        pixel_queue.push_back('{column: PIX_W'(column), row: PIX_W'(row)});
        items_sent++;
    endtask

    // every queued pixel has come back
    task automatic wait_idle();
        while (results_checked != items_sent) @(posedge aclk);
        @(posedge aclk);
    endtask

    // random plane around the origin, small images mostly
    task automatic pick_plane();
        int          cx;
        int          cy;
        int          span_x;
        int          span_y;
        int          r;
        logic [15:0] cols;
        logic [15:0] rows;
        cx     = int'($urandom_range(0, 2 << 20)) - (1 << 20);
        cy     = int'($urandom_range(0, 2 << 20)) - (1 << 20);
        span_x = int'($urandom_range(1 << 12, 3 << 20));
        span_y = int'($urandom_range(1 << 12, 3 << 20));
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(REG_X_LEFT, cx + span_x);
            cfg_write(REG_X_RIGHT, cx - span_x);
        end else begin
            cfg_write(REG_X_LEFT, cx - span_x);
            cfg_write(REG_X_RIGHT, cx + span_x);
        end
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(REG_Y_BOTTOM, cy + span_y);
            cfg_write(REG_Y_TOP, cy - span_y);
        end else begin
            cfg_write(REG_Y_BOTTOM, cy - span_y);
            cfg_write(REG_Y_TOP, cy + span_y);
        end
        r = $urandom_range(0, 19);
        cols = (r < 16) ? 16'($urandom_range(2, 48)) :
               (r < 19) ? 16'($urandom_range(49, 2000)) : 16'($urandom_range(2, 65535));
        r = $urandom_range(0, 19);
        rows = (r < 16) ? 16'($urandom_range(2, 48)) :
               (r < 19) ? 16'($urandom_range(49, 2000)) : 16'($urandom_range(2, 65535));
        cfg_write(REG_IMAGE_WIDTH, {16'($urandom), cols});
        cfg_write(REG_IMAGE_HEIGHT, {16'($urandom), rows});
        // a few well-known constants, otherwise anything in the unit square
        case ($urandom_range(0, 5))
            0: begin
                cfg_write(REG_C_REAL, -838861);
                cfg_write(REG_C_IMAG, 163578);
            end
            1: begin
                cfg_write(REG_C_REAL, -419430);
                cfg_write(REG_C_IMAG, 629146);
            end
            2: begin
                cfg_write(REG_C_REAL, 298844);
                cfg_write(REG_C_IMAG, 10486);
            end
            3: begin
                cfg_write(REG_C_REAL, -735850);
                cfg_write(REG_C_IMAG, -402865);
            end
            default: begin
                cfg_write(REG_C_REAL, int'($urandom_range(0, 2 << 20)) - (1 << 20));
                cfg_write(REG_C_IMAG, int'($urandom_range(0, 2 << 20)) - (1 << 20));
            end
        endcase
    endtask

    // pixel driver: one transaction at a time from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            feed_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_colors.push_back(predict_pixel(s_column, s_row));
                feed_gap = idle_len(feed_idle_on);
            end
            if (s_valid && !s_ready) begin
                // hold the offered pixel
            end else if (feed_gap > 0) begin
                feed_gap--;
                s_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                next_pixel = pixel_queue.pop_front();
                s_valid  <= 1'b1;
                s_column <= next_pixel.column;
                s_row    <= next_pixel.row;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            drain_gap = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch("result with no pixel in flight");
                end else begin
                    want = expected_colors.pop_front();
                    check_field("in_set", m_in_set, want.in_set, want);
                    check_field("blue", m_blue, want.blue, want);
                    check_field("green", m_green, want.green, want);
                    check_field("red", m_red, want.red, want);
                    results_checked++;
                    // long hold-off so the unit backs up into its input
                    if (results_checked % 250 == 40) hold_left = HOLD_CYCLES;
                end
                drain_gap = idle_len(drain_idle_on);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (drain_gap > 0) begin
                drain_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        int p;
        int k;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset plane: corners, center, clamped indexes
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(0, 1023);
        queue_pixel(1023, 0);
        queue_pixel(511, 511);
        queue_pixel(512, 512);
        queue_pixel(1023, 512);
        queue_pixel(512, 0);
        queue_pixel(768, 256);
        queue_pixel(256, 700);
        queue_pixel(1024, 1024);
        queue_pixel(65535, 65535);
        queue_pixel(65535, 300);
        queue_pixel(300, 65535);
        wait_idle();

        // full-range limits, reversed imaginary axis, saturating orbits
        cfg_write(REG_X_LEFT, 32'h8000_0000);
        cfg_write(REG_X_RIGHT, 32'h7FFF_FFFF);
        cfg_write(REG_Y_BOTTOM, 32'h7FFF_FFFF);
        cfg_write(REG_Y_TOP, 32'h8000_0000);
        cfg_write(REG_IMAGE_WIDTH, 32'hABCD_FFFF);
        cfg_write(REG_IMAGE_HEIGHT, 32'h0000_0002);
        cfg_write(REG_C_REAL, 32'h8000_0000);
        cfg_write(REG_C_IMAG, 32'h7FFF_FFFF);
        queue_pixel(0, 0);
        queue_pixel(65535, 1);
        queue_pixel(32767, 0);
        queue_pixel(32768, 1);
        queue_pixel(65534, 65535);
        wait_idle();

        // one-column, zero-row image: every pixel maps to the lower limits
        cfg_write(REG_X_LEFT, 32'h0004_0000);
        cfg_write(REG_X_RIGHT, 32'hFFF0_0000);
        cfg_write(REG_Y_BOTTOM, 32'h0000_0000);
        cfg_write(REG_Y_TOP, 32'h0010_0000);
        cfg_write(REG_IMAGE_WIDTH, 32'h0000_0001);
        cfg_write(REG_IMAGE_HEIGHT, 32'h0000_0000);
        cfg_write(REG_C_REAL, C_REAL_RESET);
        cfg_write(REG_C_IMAG, C_IMAG_RESET);
        queue_pixel(0, 0);
        queue_pixel(7, 3);
        queue_pixel(65535, 65535);
        wait_idle();

        // zero-column, one-row image at an escaping point
        cfg_write(REG_X_LEFT, 32'h0020_0000);
        cfg_write(REG_Y_BOTTOM, 32'h0008_0000);
        cfg_write(REG_IMAGE_WIDTH, 32'h0000_0000);
        cfg_write(REG_IMAGE_HEIGHT, 32'h0000_0001);
        cfg_write(REG_C_REAL, 32'h0004_0000);
        cfg_write(REG_C_IMAG, 32'h0000_0000);
        queue_pixel(0, 0);
        queue_pixel(1, 1);
        queue_pixel(65535, 0);
        wait_idle();

        // random planes, idling switched per phase
        for (p = 0; p < 6; p++) begin
            feed_idle_on  = (p % 3 != 1);
            drain_idle_on = (p % 3 != 2);
            pick_plane();
            for (k = 0; k < 105; k++)
                queue_pixel(rand_index(plane.image_width), rand_index(plane.image_height));
            wait_idle();
        end

        repeat (600) @(posedge aclk);
        if (expected_colors.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_colors.size()));
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
